### hw/rtl/scs_pkg.sv
// Shared types, constants and helper functions for the subtitle cue scheduler.
// Used by every module of the block but scs_ram; depends on nothing.
package scs_pkg;

   localparam int QUEUE_DEPTH  = 256;
   localparam int ADDR_BITS    = $clog2(QUEUE_DEPTH);
   localparam int FILL_BITS    = $clog2(QUEUE_DEPTH + 1);
   localparam int TICKS_PER_MS = 90;
   localparam int SERIAL_BITS  = 32;
   localparam int TIME_BITS    = 39;
   localparam int PROD_BITS    = 32 + $clog2(TICKS_PER_MS + 1);

   localparam logic [TIME_BITS-1:0] TIME_MAX       = '1;
   localparam logic [23:0]          DURATION_RESET = 24'd270000;

   localparam logic [1:0] CMD_ARRIVAL = 2'd0;
   localparam logic [1:0] CMD_TICK    = 2'd1;
   localparam logic [1:0] CMD_RESET   = 2'd2;

   localparam logic [1:0] ARR_NONE   = 2'd0;
   localparam logic [1:0] ARR_QUEUED = 2'd1;
   localparam logic [1:0] ARR_EMPTY  = 2'd2;
   localparam logic [1:0] ARR_FULL   = 2'd3;

   localparam int         CSR_INDEX_BITS = 2;
   localparam int         CSR_DATA_BITS  = 24;
   localparam logic [1:0] CSR_TIMING     = 2'd0;
   localparam logic [1:0] CSR_DURATION   = 2'd1;

   typedef struct packed {
      logic [1:0]  command;
      logic [32:0] packet_time;
      logic [31:0] start_offset_ms;
      logic [31:0] end_offset_ms;
      logic [32:0] packet_length;
      logic        has_text;
      logic        has_regions;
      logic [38:0] audio_clock;
      logic        audio_valid;
      logic [38:0] video_clock;
      logic        video_valid;
   } req_type;

   typedef struct packed {
      logic        hide_now;
      logic        show_now;
      logic [31:0] cue_id;
      logic        cue_is_bitmap;
      logic [1:0]  arrival_status;
      logic [8:0]  queue_level;
   } rsp_type;

   typedef struct packed {
      logic [TIME_BITS-1:0]   start_time;
      logic [TIME_BITS-1:0]   stop_time;
      logic [SERIAL_BITS-1:0] serial;
      logic                   bitmap;
   } entry_type;

   localparam int ENTRY_BITS = $bits(entry_type);

   typedef struct packed {
      logic load;
      logic mul;
      logic add;
      logic cap;
      logic push;
      logic tick;
      logic scan;
      logic finish;
      logic clear;
      logic emit;
   } ctl_type;

   typedef struct packed {
      logic [1:0] command;
      logic       clock_ok;
      logic       fill_zero;
      logic       push_ok;
      logic       scan_done;
      logic       out_free;
   } sts_type;

   function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                   input logic [TIME_BITS-1:0] b);
      logic [TIME_BITS:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[TIME_BITS] ? TIME_MAX : sum[TIME_BITS-1:0];
   endfunction

   function automatic logic [TIME_BITS-1:0] clamp_time(input logic [PROD_BITS-1:0] p);
      logic [TIME_BITS+PROD_BITS-1:0] wide;
      wide = (TIME_BITS+PROD_BITS)'(p);
      return (wide > (TIME_BITS+PROD_BITS)'(TIME_MAX)) ? TIME_MAX : wide[TIME_BITS-1:0];
   endfunction

   function automatic logic [ADDR_BITS-1:0] slot_add(input logic [ADDR_BITS-1:0] base,
                                                    input logic [FILL_BITS-1:0] off);
      logic [FILL_BITS:0] sum;
      sum = (FILL_BITS+1)'(base) + (FILL_BITS+1)'(off);
      if (sum >= (FILL_BITS+1)'(QUEUE_DEPTH)) begin
         sum = sum - (FILL_BITS+1)'(QUEUE_DEPTH);
      end
      return sum[ADDR_BITS-1:0];
   endfunction

endpackage

### hw/rtl/scs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package dependency.
module scs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/scs_ctrl.sv
// Sequencer of the cue scheduler: steps arrivals, ticks, queue resets and unknown commands.
// Depends on scs_pkg for the command and status structs.
module scs_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  scs_pkg::sts_type sts,
   output scs_pkg::ctl_type ctl
);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_DECODE = 4'd1;
   localparam logic [3:0] ST_MUL    = 4'd2;
   localparam logic [3:0] ST_ADD    = 4'd3;
   localparam logic [3:0] ST_CAP    = 4'd4;
   localparam logic [3:0] ST_PUSH   = 4'd5;
   localparam logic [3:0] ST_TICK   = 4'd6;
   localparam logic [3:0] ST_SCAN   = 4'd7;
   localparam logic [3:0] ST_FINISH = 4'd8;
   localparam logic [3:0] ST_CLEAR  = 4'd9;
   localparam logic [3:0] ST_EMIT   = 4'd10;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   always_comb begin
      state_in  = state_ff;
      ctl       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               ctl.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (sts.command)
               scs_pkg::CMD_ARRIVAL: state_in = ST_MUL;
               scs_pkg::CMD_TICK:    state_in = ST_TICK;
               default:              state_in = ST_CLEAR;
            endcase
         end
         ST_MUL: begin
            ctl.mul  = 1'b1;
            state_in = ST_ADD;
         end
         ST_ADD: begin
            ctl.add  = 1'b1;
            state_in = ST_CAP;
         end
         ST_CAP: begin
            ctl.cap  = 1'b1;
            state_in = sts.push_ok ? ST_PUSH : ST_EMIT;
         end
         ST_PUSH: begin
            ctl.push = 1'b1;
            state_in = ST_EMIT;
         end
         ST_TICK: begin
            ctl.tick = 1'b1;
            if (!sts.clock_ok) begin
               state_in = ST_EMIT;
            end else if (sts.fill_zero) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            ctl.scan = 1'b1;
            if (sts.scan_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            ctl.finish = 1'b1;
            state_in   = ST_EMIT;
         end
         ST_CLEAR: begin
            ctl.clear = 1'b1;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               ctl.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### hw/rtl/scs_dpath.sv
// Datapath of the cue scheduler: timing math, cue queue, tick scan, result register.
// Depends on scs_pkg and scs_ram.
module scs_dpath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  scs_pkg::req_type                      req_data,
   input  logic                                  csr_write,
   input  logic [scs_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [scs_pkg::CSR_DATA_BITS-1:0]     csr_data,
   input  scs_pkg::ctl_type                      ctl,
   output scs_pkg::sts_type                      sts,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output scs_pkg::rsp_type                      rsp_data
);

   scs_pkg::req_type                      req_ff;
   logic                                  timing_ff;
   logic [23:0]                           duration_ff;
   logic [scs_pkg::TIME_BITS-1:0]         sprod_ff, sprod_in;
   logic [scs_pkg::TIME_BITS-1:0]         eprod_ff, eprod_in;
   logic [scs_pkg::TIME_BITS-1:0]         start_ff, start_in;
   logic [scs_pkg::TIME_BITS-1:0]         stop_ff, stop_in;
   logic [scs_pkg::ADDR_BITS-1:0]         head_ff, head_in;
   logic [scs_pkg::FILL_BITS-1:0]         fill_ff, fill_in;
   logic [scs_pkg::SERIAL_BITS-1:0]       serial_ff, serial_in;
   logic [scs_pkg::SERIAL_BITS-1:0]       shown_ff, shown_in;
   logic                                  hide_pend_ff, hide_pend_in;
   logic [scs_pkg::ADDR_BITS-1:0]         ptr_ff, ptr_in;
   logic [scs_pkg::FILL_BITS-1:0]         rem_ff, rem_in;
   logic                                  prune_ff, prune_in;
   logic                                  act_ff, act_in;
   logic [scs_pkg::SERIAL_BITS-1:0]       act_serial_ff, act_serial_in;
   logic                                  act_bmp_ff, act_bmp_in;
   logic                                  o_hide_ff, o_hide_in;
   logic                                  o_show_ff, o_show_in;
   logic [scs_pkg::SERIAL_BITS-1:0]       o_id_ff, o_id_in;
   logic                                  o_bmp_ff, o_bmp_in;
   logic [1:0]                            o_arr_ff, o_arr_in;
   logic                                  rsp_valid_ff, rsp_valid_in;
   scs_pkg::rsp_type                      rsp_ff, rsp_in;

   logic                                  wr_en;
   logic [scs_pkg::ADDR_BITS-1:0]         wr_addr;
   scs_pkg::entry_type                    wr_entry;
   logic [scs_pkg::ADDR_BITS-1:0]         rd_addr;
   logic [scs_pkg::ENTRY_BITS-1:0]        rd_data;
   scs_pkg::entry_type                    rd_entry;

   logic [scs_pkg::TIME_BITS-1:0]         tick_clock;
   logic [scs_pkg::TIME_BITS-1:0]         pt_time;
   logic [scs_pkg::TIME_BITS-1:0]         dur_time;
   logic                                  empty_cue;
   logic                                  have_dur, have_dec;
   logic [scs_pkg::TIME_BITS-1:0]         dur_end, dec_end, def_end;
   logic [scs_pkg::ADDR_BITS-1:0]         last_slot;
   logic [scs_pkg::SERIAL_BITS-1:0]       serial_inc;
   logic                                  pop, early_stop;

   assign rd_entry   = rd_data;
   assign tick_clock = req_ff.audio_valid ? req_ff.audio_clock : req_ff.video_clock;
   assign pt_time    = scs_pkg::TIME_BITS'(req_ff.packet_time);
   assign dur_time   = scs_pkg::TIME_BITS'(duration_ff);
   assign empty_cue  = !req_ff.has_text && !req_ff.has_regions;
   assign have_dur   = req_ff.packet_length != '0;
   assign have_dec   = (req_ff.end_offset_ms != '0) && (req_ff.end_offset_ms != '1);
   assign dur_end    = scs_pkg::sat_add(pt_time, scs_pkg::TIME_BITS'(req_ff.packet_length));
   assign dec_end    = scs_pkg::sat_add(pt_time, eprod_ff);
   assign def_end    = scs_pkg::sat_add(pt_time, dur_time);
   assign last_slot  = scs_pkg::slot_add(head_ff, fill_ff - scs_pkg::FILL_BITS'(1));
   assign serial_inc = serial_ff + scs_pkg::SERIAL_BITS'(1);
   assign pop        = prune_ff && (rd_entry.stop_time <= tick_clock);
   assign early_stop = !pop && (rd_entry.start_time > tick_clock);

   assign sts.command   = req_ff.command;
   assign sts.clock_ok  = req_ff.audio_valid || req_ff.video_valid;
   assign sts.fill_zero = fill_ff == '0;
   assign sts.push_ok   = !empty_cue && (fill_ff < scs_pkg::FILL_BITS'(scs_pkg::QUEUE_DEPTH));
   assign sts.scan_done = early_stop || (rem_ff == scs_pkg::FILL_BITS'(1));
   assign sts.out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rd_addr = scs_pkg::slot_add(ptr_ff, scs_pkg::FILL_BITS'(1));
      if (ctl.add) begin
         rd_addr = last_slot;
      end else if (ctl.tick) begin
         rd_addr = head_ff;
      end
   end

   always_comb begin
      wr_en    = 1'b0;
      wr_addr  = last_slot;
      wr_entry = rd_entry;
      wr_entry.stop_time = start_ff;
      if (ctl.cap && (fill_ff != '0) && rd_entry.bitmap && (rd_entry.stop_time > start_ff)
          && (req_ff.has_regions || !req_ff.has_text)) begin
         wr_en = 1'b1;
      end
      if (ctl.push) begin
         wr_en    = 1'b1;
         wr_addr  = scs_pkg::slot_add(head_ff, fill_ff);
         wr_entry = '{start_time: start_ff, stop_time: stop_ff, serial: serial_ff,
                      bitmap: req_ff.has_regions};
      end
   end

   scs_ram #(
      .WIDTH (scs_pkg::ENTRY_BITS),
      .DEPTH (scs_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      sprod_in      = sprod_ff;
      eprod_in      = eprod_ff;
      start_in      = start_ff;
      stop_in       = stop_ff;
      head_in       = head_ff;
      fill_in       = fill_ff;
      serial_in     = serial_ff;
      shown_in      = shown_ff;
      hide_pend_in  = hide_pend_ff;
      ptr_in        = ptr_ff;
      rem_in        = rem_ff;
      prune_in      = prune_ff;
      act_in        = act_ff;
      act_serial_in = act_serial_ff;
      act_bmp_in    = act_bmp_ff;
      o_hide_in     = o_hide_ff;
      o_show_in     = o_show_ff;
      o_id_in       = o_id_ff;
      o_bmp_in      = o_bmp_ff;
      o_arr_in      = o_arr_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      if (ctl.load) begin
         o_hide_in = 1'b0;
         o_show_in = 1'b0;
         o_id_in   = '0;
         o_bmp_in  = 1'b0;
         o_arr_in  = scs_pkg::ARR_NONE;
      end
      if (ctl.mul) begin
         sprod_in = scs_pkg::clamp_time(scs_pkg::PROD_BITS'(req_ff.start_offset_ms)
                                        * scs_pkg::PROD_BITS'(scs_pkg::TICKS_PER_MS));
         eprod_in = scs_pkg::clamp_time(scs_pkg::PROD_BITS'(req_ff.end_offset_ms)
                                        * scs_pkg::PROD_BITS'(scs_pkg::TICKS_PER_MS));
      end
      if (ctl.add) begin
         start_in = scs_pkg::sat_add(pt_time, sprod_ff);
         stop_in  = def_end;
         if (timing_ff) begin
            if (have_dec) begin
               stop_in = dec_end;
            end else if (have_dur) begin
               stop_in = dur_end;
            end
         end else begin
            if (have_dur) begin
               stop_in = dur_end;
            end else if (have_dec) begin
               stop_in = dec_end;
            end
         end
      end
      if (ctl.cap) begin
         if (stop_ff <= start_ff) begin
            stop_in = scs_pkg::sat_add(start_ff, dur_time);
         end
         if (empty_cue) begin
            o_arr_in = scs_pkg::ARR_EMPTY;
         end else if (!sts.push_ok) begin
            o_arr_in = scs_pkg::ARR_FULL;
         end
      end
      if (ctl.push) begin
         fill_in   = fill_ff + scs_pkg::FILL_BITS'(1);
         serial_in = (serial_inc == '0) ? scs_pkg::SERIAL_BITS'(1) : serial_inc;
         o_id_in   = serial_ff;
         o_arr_in  = scs_pkg::ARR_QUEUED;
      end
      if (ctl.tick) begin
         if (hide_pend_ff) begin
            hide_pend_in = 1'b0;
            shown_in     = '0;
            o_hide_in    = 1'b1;
         end
         ptr_in   = head_ff;
         rem_in   = fill_ff;
         prune_in = 1'b1;
         act_in   = 1'b0;
      end
      if (ctl.scan) begin
         ptr_in = scs_pkg::slot_add(ptr_ff, scs_pkg::FILL_BITS'(1));
         rem_in = rem_ff - scs_pkg::FILL_BITS'(1);
         if (pop) begin
            head_in = scs_pkg::slot_add(head_ff, scs_pkg::FILL_BITS'(1));
            fill_in = fill_ff - scs_pkg::FILL_BITS'(1);
         end else begin
            prune_in = 1'b0;
            if (!early_stop && (tick_clock < rd_entry.stop_time)) begin
               act_in        = 1'b1;
               act_serial_in = rd_entry.serial;
               act_bmp_in    = rd_entry.bitmap;
            end
         end
      end
      if (ctl.finish) begin
         if (act_ff) begin
            if (act_serial_ff != shown_ff) begin
               shown_in  = act_serial_ff;
               o_show_in = 1'b1;
               o_id_in   = act_serial_ff;
               o_bmp_in  = act_bmp_ff;
            end
         end else if (shown_ff != '0) begin
            shown_in  = '0;
            o_hide_in = 1'b1;
         end
      end
      if (ctl.clear && (req_ff.command == scs_pkg::CMD_RESET)) begin
         fill_in      = '0;
         head_in      = '0;
         hide_pend_in = 1'b1;
      end
      if (ctl.emit) begin
         rsp_valid_in = 1'b1;
         rsp_in = '{hide_now: o_hide_ff, show_now: o_show_ff, cue_id: o_id_ff,
                    cue_is_bitmap: o_bmp_ff, arrival_status: o_arr_ff,
                    queue_level: fill_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         req_ff <= req_data;
      end
      sprod_ff      <= sprod_in;
      eprod_ff      <= eprod_in;
      start_ff      <= start_in;
      stop_ff       <= stop_in;
      ptr_ff        <= ptr_in;
      rem_ff        <= rem_in;
      prune_ff      <= prune_in;
      act_ff        <= act_in;
      act_serial_ff <= act_serial_in;
      act_bmp_ff    <= act_bmp_in;
      o_hide_ff     <= o_hide_in;
      o_show_ff     <= o_show_in;
      o_id_ff       <= o_id_in;
      o_bmp_ff      <= o_bmp_in;
      o_arr_ff      <= o_arr_in;
      rsp_ff        <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         fill_ff      <= '0;
         serial_ff    <= scs_pkg::SERIAL_BITS'(1);
         shown_ff     <= '0;
         hide_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         serial_ff    <= serial_in;
         shown_ff     <= shown_in;
         hide_pend_ff <= hide_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timing_ff   <= 1'b0;
         duration_ff <= scs_pkg::DURATION_RESET;
      end else if (csr_write) begin
         if (csr_index == scs_pkg::CSR_TIMING) begin
            timing_ff <= csr_data[0];
         end else if (csr_index == scs_pkg::CSR_DURATION) begin
            duration_ff <= csr_data;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### hw/rtl/subtitle_cue_scheduler.sv
// Subtitle cue scheduler: one request in, one result out, one item in process.
// An arrival steps through the decode, multiply, add, cap, push and emit states (push
// is skipped when the cue is not queued). A tick reads the cue queue memory one entry
// per cycle and stops at the first cue not yet started or after the last of up to 256
// queued cues; with neither clock valid it skips the scan. Other commands pass through
// decode, clear and emit. The next request is taken in the cycle after the result is
// loaded; a finished result waits in the output register, so the next request is
// taken while it is held. No clearing pass follows reset.
// Depends on scs_pkg, scs_ctrl, scs_dpath and scs_ram.
module subtitle_cue_scheduler (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  scs_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output scs_pkg::rsp_type                   rsp_data,
   input  logic                               csr_write,
   input  logic [scs_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [scs_pkg::CSR_DATA_BITS-1:0]  csr_data
);

   scs_pkg::ctl_type ctl;
   scs_pkg::sts_type sts;

   scs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .ctl       (ctl)
   );

   scs_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .ctl       (ctl),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

`ifndef NO_ASSERTIONS
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.queue_level <= scs_pkg::FILL_BITS'(scs_pkg::QUEUE_DEPTH))
      else $error("queue level beyond depth");

   a_show_serial: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.show_now || rsp_data.arrival_status == scs_pkg::ARR_QUEUED)
      |-> rsp_data.cue_id != '0)
      else $error("zero serial shown or queued");

   a_strobes: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctl.load, ctl.push, ctl.scan, ctl.emit, ctl.cap}))
      else $error("overlapping sequencer strobes");

   a_emit_only_free: assert property (@(posedge clock) disable iff (reset)
      ctl.emit |-> !(rsp_valid && rsp_stall))
      else $error("result overwritten while stalled");
`endif

endmodule

### tb/subtitle_cue_checker.sv
// Result checker for subtitle_cue_scheduler: watches both channels and the register port,
// keeps its own copy of the cue queue and compares every result with its prediction.
// Depends on scs_pkg.
module subtitle_cue_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  scs_pkg::req_type                   req_data,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  scs_pkg::rsp_type                   rsp_data,
   input  logic                               csr_write,
   input  logic [scs_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [scs_pkg::CSR_DATA_BITS-1:0]  csr_data,
   output int                                 fail_count,
   output int                                 results_due
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [63:0] TIME_LIMIT = (64'd1 << scs_pkg::TIME_BITS) - 64'd1;

   logic [scs_pkg::TIME_BITS-1:0]   cue_start  [scs_pkg::QUEUE_DEPTH];
   logic [scs_pkg::TIME_BITS-1:0]   cue_stop   [scs_pkg::QUEUE_DEPTH];
   logic [scs_pkg::SERIAL_BITS-1:0] cue_serial [scs_pkg::QUEUE_DEPTH];
   logic                            cue_bitmap [scs_pkg::QUEUE_DEPTH];
   int                              head;
   int                              fill;
   logic [scs_pkg::SERIAL_BITS-1:0] serial_next;
   logic [scs_pkg::SERIAL_BITS-1:0] on_screen;
   logic                            hide_owed;
   logic                            timing_first;
   logic [23:0]                     fallback_len;
   scs_pkg::rsp_type                due_results [$];
   scs_pkg::rsp_type                oldest;
   int                              errors = 0;

   function automatic logic [scs_pkg::TIME_BITS-1:0] clip_sum(input logic [63:0] a,
                                                             input logic [63:0] b);
      logic [63:0] sum;
      sum = a + b;
      return (sum > TIME_LIMIT) ? TIME_LIMIT[scs_pkg::TIME_BITS-1:0]
                                : sum[scs_pkg::TIME_BITS-1:0];
   endfunction

   function automatic int slot(input int i);
      return (head + i) % scs_pkg::QUEUE_DEPTH;
   endfunction

   function automatic scs_pkg::rsp_type schedule_request(input scs_pkg::req_type r);
      scs_pkg::rsp_type                o;
      logic [scs_pkg::TIME_BITS-1:0]   start;
      logic [scs_pkg::TIME_BITS-1:0]   stop;
      logic [scs_pkg::TIME_BITS-1:0]   clk_now;
      logic                            have_len;
      logic                            have_dec;
      logic                            empty;
      logic                            clk_ok;
      logic                            found;
      logic                            found_bitmap;
      logic [scs_pkg::SERIAL_BITS-1:0] found_serial;
      int                              last;
      int                              s;
      int                              i;
      o = '0;
      case (r.command)
         scs_pkg::CMD_ARRIVAL: begin
            start = clip_sum(64'(r.packet_time),
                             64'(r.start_offset_ms) * scs_pkg::TICKS_PER_MS);
            have_len = (r.packet_length != '0);
            have_dec = (r.end_offset_ms != '0) && (r.end_offset_ms != '1);
            stop = clip_sum(64'(r.packet_time), 64'(fallback_len));
            if (timing_first) begin
               if (have_dec) begin
                  stop = clip_sum(64'(r.packet_time),
                                  64'(r.end_offset_ms) * scs_pkg::TICKS_PER_MS);
               end else if (have_len) begin
                  stop = clip_sum(64'(r.packet_time), 64'(r.packet_length));
               end
            end else begin
               if (have_len) begin
                  stop = clip_sum(64'(r.packet_time), 64'(r.packet_length));
               end else if (have_dec) begin
                  stop = clip_sum(64'(r.packet_time),
                                  64'(r.end_offset_ms) * scs_pkg::TICKS_PER_MS);
               end
            end
            if (stop <= start) begin
               stop = clip_sum(64'(start), 64'(fallback_len));
            end
            empty = !r.has_text && !r.has_regions;
            // cut the previous bitmap page short at the new start
            if (fill > 0 && (empty || r.has_regions)) begin
               last = slot(fill - 1);
               if (cue_bitmap[last] && cue_stop[last] > start) begin
                  cue_stop[last] = start;
               end
            end
            if (empty) begin
               o.arrival_status = scs_pkg::ARR_EMPTY;
            end else if (fill >= scs_pkg::QUEUE_DEPTH) begin
               o.arrival_status = scs_pkg::ARR_FULL;
            end else begin
               s = slot(fill);
               cue_start[s] = start;
               cue_stop[s] = stop;
               cue_serial[s] = serial_next;
               cue_bitmap[s] = r.has_regions;
               fill++;
               o.cue_id = serial_next;
               o.arrival_status = scs_pkg::ARR_QUEUED;
               serial_next = serial_next + 1'b1;
               if (serial_next == '0) begin
                  serial_next = scs_pkg::SERIAL_BITS'(1);
               end
            end
         end
         scs_pkg::CMD_TICK: begin
            if (hide_owed) begin
               hide_owed = 1'b0;
               on_screen = '0;
               o.hide_now = 1'b1;
            end
            clk_ok = 1'b1;
            clk_now = '0;
            if (r.audio_valid) begin
               clk_now = r.audio_clock;
            end else if (r.video_valid) begin
               clk_now = r.video_clock;
            end else begin
               clk_ok = 1'b0;
            end
            if (clk_ok) begin
               while (fill > 0 && cue_stop[head] <= clk_now) begin
                  head = (head + 1) % scs_pkg::QUEUE_DEPTH;
                  fill--;
               end
               found = 1'b0;
               found_bitmap = 1'b0;
               found_serial = '0;
               for (i = 0; i < fill; i++) begin
                  s = slot(i);
                  if (cue_start[s] > clk_now) break;
                  if (clk_now < cue_stop[s]) begin
                     found = 1'b1;
                     found_serial = cue_serial[s];
                     found_bitmap = cue_bitmap[s];
                  end
               end
               if (found) begin
                  if (found_serial != on_screen) begin
                     on_screen = found_serial;
                     o.show_now = 1'b1;
                     o.cue_id = found_serial;
                     o.cue_is_bitmap = found_bitmap;
                  end
               end else if (on_screen != '0) begin
                  on_screen = '0;
                  o.hide_now = 1'b1;
               end
            end
         end
         scs_pkg::CMD_RESET: begin
            fill = 0;
            head = 0;
            hide_owed = 1'b1;
         end
         default: begin
         end
      endcase
      o.queue_level = 9'(fill);
      return o;
   endfunction

   task automatic note_field(input string field, input logic [63:0] want,
                             input logic [63:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t %s: expected %0h, got %0h", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         head = 0;
         fill = 0;
         serial_next = scs_pkg::SERIAL_BITS'(1);
         on_screen = '0;
         hide_owed = 1'b0;
         timing_first = 1'b0;
         fallback_len = scs_pkg::DURATION_RESET;
         due_results.delete();
      end else begin
         if (csr_write) begin
            case (csr_index)
               scs_pkg::CSR_TIMING:   timing_first = csr_data[0];
               scs_pkg::CSR_DURATION: fallback_len = csr_data[23:0];
               default: begin
               end
            endcase
         end
         if (req_valid && !req_stall) begin
            due_results.insert(due_results.size(), schedule_request(req_data));
         end
         if (rsp_valid && !rsp_stall) begin
            if (due_results.size() == 0) begin
               errors++;
               $display("%0t result: expected none, got %h", $time, rsp_data);
            end else begin
               oldest = due_results[0];
               due_results.delete(0);
               note_field("hide_now", 64'(oldest.hide_now), 64'(rsp_data.hide_now));
               note_field("show_now", 64'(oldest.show_now), 64'(rsp_data.show_now));
               note_field("cue_id", 64'(oldest.cue_id), 64'(rsp_data.cue_id));
               note_field("cue_is_bitmap", 64'(oldest.cue_is_bitmap),
                          64'(rsp_data.cue_is_bitmap));
               note_field("arrival_status", 64'(oldest.arrival_status),
                          64'(rsp_data.arrival_status));
               note_field("queue_level", 64'(oldest.queue_level),
                          64'(rsp_data.queue_level));
            end
         end
      end
      fail_count <= errors;
      results_due <= due_results.size();
   end

endmodule

### tb/testbench.sv
// Top of the subtitle_cue_scheduler testbench: clock, reset, register writes, request
// stimulus and result stalls; the verdict comes from subtitle_cue_checker.
// Depends on scs_pkg, subtitle_cue_scheduler and subtitle_cue_checker.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int         CYCLE_LIMIT  = 2_000_000;
   localparam int         HOLD_CYCLES  = 400;
   localparam int         DRAIN_CYCLES = 20;
   localparam logic [1:0] CMD_UNKNOWN  = 2'd3;
   localparam logic [1:0] CSR_SPARE    = 2'd3;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_stall;
   scs_pkg::req_type                   req_data = '0;
   logic                               rsp_valid;
   logic                               rsp_stall = 1'b0;
   scs_pkg::rsp_type                   rsp_data;
   logic                               csr_write = 1'b0;
   logic [scs_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [scs_pkg::CSR_DATA_BITS-1:0]  csr_data = '0;
   int                                 fail_count;
   int                                 results_due;
   int                                 send_idle_pct = 0;
   int                                 recv_idle_pct = 0;
   logic                               hold_rsp = 1'b0;
   logic                               pressure_go = 1'b0;
   int                                 cycle_count = 0;
   logic [32:0]                        timeline = '0;

   subtitle_cue_scheduler dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   subtitle_cue_checker cue_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .fail_count  (fail_count),
      .results_due (results_due)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= hold_rsp || ($urandom_range(0, 99) < recv_idle_pct);
   end

   initial begin
      wait (pressure_go);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[subtitle_cue_scheduler] ERROR");
      $finish;
   end

   function automatic logic [38:0] rand39();
      return 39'({$urandom(), $urandom()});
   endfunction

   function automatic scs_pkg::req_type scramble();
      scs_pkg::req_type r;
      r.command         = 2'($urandom_range(0, 3));
      r.packet_time     = 33'({$urandom(), $urandom()});
      r.start_offset_ms = $urandom();
      r.end_offset_ms   = $urandom();
      r.packet_length   = 33'({$urandom(), $urandom()});
      r.has_text        = 1'($urandom());
      r.has_regions     = 1'($urandom());
      r.audio_clock     = rand39();
      r.audio_valid     = 1'($urandom());
      r.video_clock     = rand39();
      r.video_valid     = 1'($urandom());
      return r;
   endfunction

   function automatic scs_pkg::req_type arrival(input logic [32:0] pt,
                                                input logic [31:0] so,
                                                input logic [31:0] eo,
                                                input logic [32:0] plen,
                                                input logic txt, input logic rgn);
      scs_pkg::req_type r;
      r = '0;
      r.command         = scs_pkg::CMD_ARRIVAL;
      r.packet_time     = pt;
      r.start_offset_ms = so;
      r.end_offset_ms   = eo;
      r.packet_length   = plen;
      r.has_text        = txt;
      r.has_regions     = rgn;
      return r;
   endfunction

   function automatic scs_pkg::req_type tick(input logic [38:0] aclk, input logic av,
                                             input logic [38:0] vclk, input logic vv);
      scs_pkg::req_type r;
      r = '0;
      r.command     = scs_pkg::CMD_TICK;
      r.audio_clock = aclk;
      r.audio_valid = av;
      r.video_clock = vclk;
      r.video_valid = vv;
      return r;
   endfunction

   // well-formed cue placed close to the running clock
   function automatic scs_pkg::req_type random_cue();
      scs_pkg::req_type r;
      logic [31:0]      eo;
      logic [32:0]      plen;
      int               kind;
      kind = $urandom_range(0, 9);
      eo = (kind < 2) ? '0 : (kind == 2) ? '1 : 32'($urandom_range(1, 4000));
      plen = $urandom_range(0, 1) ? 33'($urandom_range(1, 400000)) : '0;
      kind = $urandom_range(0, 7);
      r = arrival(timeline + 33'($urandom_range(0, 4500)), 32'($urandom_range(0, 150)),
                  eo, plen, (kind == 7) || (kind >= 1 && kind <= 3), kind >= 4);
      r.audio_clock = rand39();
      r.audio_valid = 1'($urandom());
      r.video_clock = rand39();
      r.video_valid = 1'($urandom());
      return r;
   endfunction

   // tick on the running clock (or with neither clock valid), then advance it
   function automatic scs_pkg::req_type random_tick();
      scs_pkg::req_type r;
      int               pick;
      pick = $urandom_range(0, 9);
      r = tick(rand39(), pick < 6, rand39(), 1'($urandom()));
      if (pick < 6) begin
         r.audio_clock = 39'(timeline);
      end else if (pick < 9) begin
         r.video_valid = 1'b1;
         r.video_clock = 39'(timeline);
      end else begin
         r.video_valid = 1'b0;
      end
      timeline = timeline + 33'($urandom_range(0, 9000));
      return r;
   endfunction

   function automatic scs_pkg::req_type random_request();
      scs_pkg::req_type r;
      int               pick;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         r = random_cue();
      end else if (pick < 85) begin
         r = random_tick();
      end else begin
         r = scramble();
         if (pick < 88) begin
            r.command = scs_pkg::CMD_RESET;
         end else if (pick < 90) begin
            r.command = CMD_UNKNOWN;
         end
      end
      return r;
   endfunction

   task automatic send_request(input scs_pkg::req_type r);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic run_mix(input int count);
      repeat (count) send_request(random_request());
   endtask

   // drop valid and wait for every outstanding result
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_due != 0) @(posedge clock);
   endtask

   task automatic program_csr(input logic timing, input logic [23:0] duration);
      csr_write <= 1'b1;
      csr_index <= scs_pkg::CSR_TIMING;
      csr_data  <= 24'(timing);
      @(posedge clock);
      csr_index <= scs_pkg::CSR_DURATION;
      csr_data  <= duration;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   initial begin
      scs_pkg::req_type r;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      send_request(tick('0, 1'b0, '0, 1'b0));
      r = scramble();
      r.command = CMD_UNKNOWN;
      send_request(r);
      send_request(arrival(33'd1000, 32'd0, 32'd50, 33'd9000, 1'b1, 1'b0));
      send_request(arrival(33'd2000, 32'd10, '1, '0, 1'b0, 1'b1));
      send_request(arrival(33'd4000, 32'd0, 32'd0, 33'd0, 1'b0, 1'b0));
      send_request(tick(39'd3000, 1'b1, 39'd0, 1'b0));
      send_request(arrival(33'd5000, 32'd0, 32'd100, 33'd0, 1'b0, 1'b1));
      send_request(arrival(33'd6000, 32'd20, 32'd0, 33'd7, 1'b1, 1'b1));
      send_request(tick(39'd0, 1'b0, 39'd7000, 1'b1));
      send_request(tick(39'd20000, 1'b1, 39'd5, 1'b1));
      send_request(arrival('1, '1, 32'hFFFF_FFFE, '1, 1'b1, 1'b1));
      send_request(tick('1, 1'b1, '0, 1'b0));
      send_request(arrival(33'd100, 32'd0, 32'd0, 33'd1000, 1'b1, 1'b0));
      send_request(tick(39'd500, 1'b1, 39'd0, 1'b0));
      r = '0;
      r.command = scs_pkg::CMD_RESET;
      send_request(r);
      send_request(tick('0, 1'b0, '0, 1'b0));
      settle();

      // unlisted register index, then a zero fallback length
      csr_write <= 1'b1;
      csr_index <= CSR_SPARE;
      csr_data  <= 24'($urandom());
      @(posedge clock);
      program_csr(1'b1, 24'd0);
      send_request(arrival(33'd1000, 32'd5, 32'd0, 33'd0, 1'b1, 1'b0));
      send_request(arrival(33'd2000, 32'd0, 32'd30, 33'd500, 1'b0, 1'b1));
      send_request(tick(39'd1450, 1'b1, 39'd0, 1'b0));
      send_request(tick(39'd2500, 1'b1, 39'd0, 1'b0));
      send_request(arrival(33'd3000, 32'd0, '1, 33'd900, 1'b1, 1'b0));
      settle();

      timeline = 33'($urandom_range(1 << 20, 1 << 30));
      program_csr(1'b1, 24'd1);
      send_idle_pct <= 13;
      recv_idle_pct <= 54;
      run_mix(300);
      settle();

      program_csr(1'b0, '1);
      send_idle_pct <= 54;
      recv_idle_pct <= 13;
      run_mix(300);
      settle();

      program_csr(1'b1, 24'($urandom_range(1000, 600000)));
      send_idle_pct <= 0;
      recv_idle_pct <= 0;
      // overfill the queue
      repeat (320) send_request(random_cue());
      pressure_go <= 1'b1;
      run_mix(280);
      settle();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("[subtitle_cue_scheduler] OK");
      end else begin
         $display("[subtitle_cue_scheduler] ERROR");
      end
      $finish;
   end

endmodule

### sim.f
hw/rtl/scs_pkg.sv
hw/rtl/scs_ram.sv
hw/rtl/scs_ctrl.sv
hw/rtl/scs_dpath.sv
hw/rtl/subtitle_cue_scheduler.sv
tb/subtitle_cue_checker.sv
tb/testbench.sv
